// ===== src/idw_pkg.sv =====
// Shared constants and width helpers for the inverse-distance corner interpolator.
`timescale 1ns / 1ps

package idw_pkg;

  // Default field widths.
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned VALUE_BITS = 24;

  // Number of corners of one cell.
  localparam int unsigned CORNERS = 4;

  // Magnitude of a coordinate difference, including the far edge of the cell.
  function automatic int unsigned dist_w(input int unsigned cb);
    return cb + 1;
  endfunction

  // Squared distance to one corner: sum of two squares.
  function automatic int unsigned sum_w(input int unsigned cb);
    return 2 * dist_w(cb) + 1;
  endfunction

  // Product of three squared distances.
  function automatic int unsigned weight_w(input int unsigned cb);
    return 3 * sum_w(cb);
  endfunction

  // Sum of four weights.
  function automatic int unsigned den_w(input int unsigned cb);
    return weight_w(cb) + 2;
  endfunction

  // Magnitude of the weighted value sum.
  function automatic int unsigned mag_w(input int unsigned cb, input int unsigned vb);
    return vb + weight_w(cb) + 2;
  endfunction

endpackage

// ===== src/idw_mulw.sv =====
// Wide by narrow multiplier, cut into registered limb products and summed after.
`timescale 1ns / 1ps

module idw_mulw #(
  parameter int unsigned AW = 70,
  parameter int unsigned BW = 35,
  parameter int unsigned LW = 35
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned NL  = (AW + LW - 1) / LW;
  localparam int unsigned ACW = NL * LW + BW;

  logic [NL*LW-1:0]   a_ext;
  logic [LW+BW-1:0]   pp_q [NL];
  logic [ACW-1:0]     acc;

  assign a_ext = (NL*LW)'(a_i);

  // One limb product per limb of the wide operand, registered.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NL; k++) begin
        pp_q[k] <= (LW+BW)'(a_ext[k*LW +: LW]) * (LW+BW)'(b_i);
      end
    end
  end

  // Shifted sum of the limb products.
  always_comb begin
    acc = '0;
    for (int k = 0; k < NL; k++) begin
      acc = acc + (ACW'(pp_q[k]) << (k * LW));
    end
  end

  assign p_o = acc[AW+BW-1:0];

endmodule

// ===== src/idw_front.sv =====
// Front pipeline: distances, weights, weighted sum and the exact-corner mean.
`timescale 1ns / 1ps

module idw_front #(
  parameter int unsigned CB = idw_pkg::COORD_BITS,
  parameter int unsigned VB = idw_pkg::VALUE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [CB-1:0] cell_x_i,
  input  logic signed [CB-1:0] cell_y_i,
  input  logic [CB-2:0]        cell_width_i,
  input  logic [CB-2:0]        cell_height_i,
  input  logic signed [CB-1:0] point_x_i,
  input  logic signed [CB-1:0] point_y_i,
  input  logic signed [VB-1:0] value_ll_i,
  input  logic signed [VB-1:0] value_lr_i,
  input  logic signed [VB-1:0] value_ur_i,
  input  logic signed [VB-1:0] value_ul_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [idw_pkg::mag_w(CB, VB)-1:0] mag_o,
  output logic [idw_pkg::den_w(CB)-1:0]     den_o,
  output logic                 neg_o,
  output logic                 hit_o,
  output logic [VB-1:0]        hres_o
);

  localparam int unsigned NS   = 10;
  localparam int unsigned NC   = idw_pkg::CORNERS;
  localparam int unsigned DW   = idw_pkg::dist_w(CB);
  localparam int unsigned SQW  = 2 * DW;
  localparam int unsigned SW   = idw_pkg::sum_w(CB);
  localparam int unsigned WW   = idw_pkg::weight_w(CB);
  localparam int unsigned DNW  = idw_pkg::den_w(CB);
  localparam int unsigned TW   = VB + WW;
  localparam int unsigned NW   = idw_pkg::mag_w(CB, VB);
  localparam int unsigned NUMW = TW + 3;
  localparam int unsigned HMW  = VB + 2;
  localparam int unsigned HSW  = VB + 3;
  localparam int unsigned KB   = HMW + 2;
  localparam int unsigned K    = KB + (KB % 2);
  localparam int unsigned MW   = K - 1;
  localparam int unsigned HPW  = HMW + MW;
  localparam longint unsigned RECIP3_FULL = ((64'd1 << K) + 64'd2) / 64'd3;
  localparam logic [MW-1:0] RECIP3 = MW'(RECIP3_FULL);

  // Stage occupancy and per-stage load enables; a stage loads when empty or draining.
  logic [NS:1]   vld_q;
  logic [NS+1:1] en;

  always_comb begin
    en[NS+1] = ready_i;
    for (int i = NS; i >= 1; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= valid_i;
      for (int i = 2; i <= NS; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign ready_o = en[1];
  assign valid_o = vld_q[NS];

  // Coordinate differences to the near and far edges of the cell.
  logic signed [CB+1:0] dxa, dxb, dya, dyb;
  logic signed [VB-1:0] vin [NC];

  assign dxa = (CB+2)'(point_x_i) - (CB+2)'(cell_x_i);
  assign dxb = dxa - (CB+2)'(cell_width_i);
  assign dya = (CB+2)'(point_y_i) - (CB+2)'(cell_y_i);
  assign dyb = dya - (CB+2)'(cell_height_i);
  assign vin = '{value_ll_i, value_lr_i, value_ur_i, value_ul_i};

  function automatic logic [DW-1:0] absd(input logic signed [CB+1:0] d);
    return DW'(d[CB+1] ? -d : d);
  endfunction

  // Payload registers of the stages.
  logic [DW-1:0]        ax1_q, bx1_q, ay1_q, by1_q;
  logic signed [VB-1:0] val_q  [1:3][NC];
  logic [VB-1:0]        vmag_q [1:6][NC];
  logic [NC-1:0]        vneg_q [1:7];
  logic [SQW-1:0]       sq2_q  [NC];
  logic [SW-1:0]        s3_q   [NC];
  logic [SW-1:0]        s4_q   [NC];
  logic [2*SW-1:0]      p01_q, p23_q;
  logic [2:0]           hcnt4_q, hcnt5_q;
  logic [HMW-1:0]       hmag4_q, hmag5_q;
  logic                 hneg4_q, hneg5_q;
  logic [HPW-1:0]       hprod5_q;
  logic [WW-1:0]        w6_q   [NC];
  logic                 hit_q  [6:NS];
  logic [VB-1:0]        hres_q [6:NS];
  logic [DNW-1:0]       den_q  [7:NS];
  logic signed [NUMW-1:0] term8_q [NC];
  logic signed [NUMW-1:0] num9_q;
  logic [NW-1:0]        mag10_q;
  logic                 neg10_q;

  // Exact-corner detection: count and sum of the corners at zero distance.
  logic signed [HSW-1:0] hsum;
  logic [2:0]            hcnt;

  always_comb begin
    hsum = '0;
    hcnt = '0;
    for (int i = 0; i < NC; i++) begin
      if (s3_q[i] == '0) begin
        hsum = hsum + HSW'(val_q[3][i]);
        hcnt = hcnt + 3'd1;
      end
    end
  end

  // Truncated mean of the exact-corner values; a third goes by reciprocal.
  logic [VB-1:0] hq;

  always_comb begin
    case (hcnt5_q)
      3'd1:    hq = VB'(hmag5_q);
      3'd2:    hq = VB'(hmag5_q >> 1);
      3'd3:    hq = hprod5_q[K +: VB];
      3'd4:    hq = VB'(hmag5_q >> 2);
      default: hq = '0;
    endcase
  end

  // Weights: each the product of the other three squared distances.
  logic [WW-1:0] wprod [NC];
  logic [TW-1:0] tv    [NC];

  idw_mulw #(.AW(2*SW), .BW(SW), .LW(SW)) u_w0 (
    .clk_i(clk_i), .en_i(en[5]), .a_i(p23_q), .b_i(s4_q[1]), .p_o(wprod[0])
  );
  idw_mulw #(.AW(2*SW), .BW(SW), .LW(SW)) u_w1 (
    .clk_i(clk_i), .en_i(en[5]), .a_i(p23_q), .b_i(s4_q[0]), .p_o(wprod[1])
  );
  idw_mulw #(.AW(2*SW), .BW(SW), .LW(SW)) u_w2 (
    .clk_i(clk_i), .en_i(en[5]), .a_i(p01_q), .b_i(s4_q[3]), .p_o(wprod[2])
  );
  idw_mulw #(.AW(2*SW), .BW(SW), .LW(SW)) u_w3 (
    .clk_i(clk_i), .en_i(en[5]), .a_i(p01_q), .b_i(s4_q[2]), .p_o(wprod[3])
  );

  // Value magnitude times weight, one per corner.
  for (genvar c = 0; c < NC; c++) begin : g_term
    idw_mulw #(.AW(WW), .BW(VB), .LW(SW)) u_tv (
      .clk_i(clk_i), .en_i(en[7]), .a_i(w6_q[c]), .b_i(vmag_q[6][c]), .p_o(tv[c])
    );
  end

  // Stage registers.
  always_ff @(posedge clk_i) begin
    // Distances and values.
    if (en[1]) begin
      ax1_q <= absd(dxa);
      bx1_q <= absd(dxb);
      ay1_q <= absd(dya);
      by1_q <= absd(dyb);
      for (int i = 0; i < NC; i++) begin
        val_q[1][i]  <= vin[i];
        vmag_q[1][i] <= vin[i][VB-1] ? VB'(-vin[i]) : VB'(vin[i]);
        vneg_q[1][i] <= vin[i][VB-1];
      end
    end
    for (int k = 2; k <= 3; k++) begin
      if (en[k]) val_q[k] <= val_q[k-1];
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) vmag_q[k] <= vmag_q[k-1];
    end
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) vneg_q[k] <= vneg_q[k-1];
    end

    // Squares.
    if (en[2]) begin
      sq2_q[0] <= SQW'(ax1_q) * SQW'(ax1_q);
      sq2_q[1] <= SQW'(bx1_q) * SQW'(bx1_q);
      sq2_q[2] <= SQW'(ay1_q) * SQW'(ay1_q);
      sq2_q[3] <= SQW'(by1_q) * SQW'(by1_q);
    end

    // Squared distances to the corners ll, lr, ur, ul.
    if (en[3]) begin
      s3_q[0] <= SW'(sq2_q[0]) + SW'(sq2_q[2]);
      s3_q[1] <= SW'(sq2_q[1]) + SW'(sq2_q[2]);
      s3_q[2] <= SW'(sq2_q[1]) + SW'(sq2_q[3]);
      s3_q[3] <= SW'(sq2_q[0]) + SW'(sq2_q[3]);
    end

    // Pair products and the exact-corner sum.
    if (en[4]) begin
      p01_q   <= (2*SW)'(s3_q[0]) * (2*SW)'(s3_q[1]);
      p23_q   <= (2*SW)'(s3_q[2]) * (2*SW)'(s3_q[3]);
      s4_q    <= s3_q;
      hcnt4_q <= hcnt;
      hneg4_q <= hsum[HSW-1];
      hmag4_q <= HMW'(hsum[HSW-1] ? -hsum : hsum);
    end

    if (en[5]) begin
      hprod5_q <= HPW'(hmag4_q) * HPW'(RECIP3);
      hmag5_q  <= hmag4_q;
      hneg5_q  <= hneg4_q;
      hcnt5_q  <= hcnt4_q;
    end

    if (en[6]) begin
      w6_q      <= wprod;
      hit_q[6]  <= (hcnt5_q != 3'd0);
      hres_q[6] <= hneg5_q ? -hq : hq;
    end
    for (int k = 7; k <= NS; k++) begin
      if (en[k]) begin
        hit_q[k]  <= hit_q[k-1];
        hres_q[k] <= hres_q[k-1];
      end
    end

    // Sum of weights.
    if (en[7]) begin
      den_q[7] <= DNW'(w6_q[0]) + DNW'(w6_q[1]) + DNW'(w6_q[2]) + DNW'(w6_q[3]);
    end
    for (int k = 8; k <= NS; k++) begin
      if (en[k]) den_q[k] <= den_q[k-1];
    end

    // Signed terms, their sum and its magnitude.
    if (en[8]) begin
      for (int i = 0; i < NC; i++) begin
        term8_q[i] <= vneg_q[7][i] ? -NUMW'(tv[i]) : NUMW'(tv[i]);
      end
    end
    if (en[9]) begin
      num9_q <= term8_q[0] + term8_q[1] + term8_q[2] + term8_q[3];
    end
    if (en[10]) begin
      mag10_q <= NW'(num9_q[NUMW-1] ? -num9_q : num9_q);
      neg10_q <= num9_q[NUMW-1];
    end
  end

  assign mag_o  = mag10_q;
  assign den_o  = den_q[NS];
  assign neg_o  = neg10_q;
  assign hit_o  = hit_q[NS];
  assign hres_o = hres_q[NS];

endmodule

// ===== src/idw_cell.sv =====
// Divider cell: resolves one quotient bit by a compare and subtract, then registers.
`timescale 1ns / 1ps

module idw_cell #(
  parameter int unsigned NW    = 131,
  parameter int unsigned DNW   = 107,
  parameter int unsigned VB    = 24,
  parameter int unsigned SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [NW-1:0]  rem_i,
  input  logic [DNW-1:0] den_i,
  input  logic [VB-1:0]  quo_i,
  input  logic           neg_i,
  input  logic           hit_i,
  input  logic [VB-1:0]  hres_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [NW-1:0]  rem_o,
  output logic [DNW-1:0] den_o,
  output logic [VB-1:0]  quo_o,
  output logic           neg_o,
  output logic           hit_o,
  output logic [VB-1:0]  hres_o
);

  logic           vld_q, en;
  logic [NW-1:0]  dsh;
  logic [NW:0]    trial;
  logic           take;
  logic [VB-1:0]  quo_d;
  logic [NW-1:0]  rem_d;
  logic [NW-1:0]  rem_q;
  logic [DNW-1:0] den_q;
  logic [VB-1:0]  quo_q, hres_q;
  logic           neg_q, hit_q;

  // Trial subtraction of the shifted divisor.
  assign dsh   = NW'(den_i) << SHIFT;
  assign trial = {1'b0, rem_i} - {1'b0, dsh};
  assign take  = !trial[NW];

  always_comb begin
    quo_d        = quo_i;
    quo_d[SHIFT] = take;
    rem_d        = take ? trial[NW-1:0] : rem_i;
  end

  // The cell loads when empty or when its beat moves on.
  assign en      = !vld_q || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      quo_q  <= quo_d;
      neg_q  <= neg_i;
      hit_q  <= hit_i;
      hres_q <= hres_i;
    end
  end

  assign valid_o = vld_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign neg_o   = neg_q;
  assign hit_o   = hit_q;
  assign hres_o  = hres_q;

endmodule

// ===== src/inverse_distance_corner_interpolate.sv =====
// Top level of the inverse-distance corner interpolator.
// Takes one beat per clock while in_stall_o is low and gives one result per
// beat. Ten front stages form the squared corner distances, the exact products
// of three of them as weights, their sum and the signed weighted value sum; a
// row of VALUE_BITS divider cells then resolves one quotient bit each, most
// significant first, and the last cell is the output register. A query point
// that lies on one or more corners gives the truncated mean of those corners'
// values instead. Every stage moves on when its successor is empty or
// draining, so input beats are taken while a finished result waits on a
// stalled output, until the stages behind it are full.
`timescale 1ns / 1ps

module inverse_distance_corner_interpolate #(
  parameter int unsigned COORD_BITS = idw_pkg::COORD_BITS,
  parameter int unsigned VALUE_BITS = idw_pkg::VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] cell_x_i,
  input  logic signed [COORD_BITS-1:0] cell_y_i,
  input  logic [COORD_BITS-2:0]        cell_width_i,
  input  logic [COORD_BITS-2:0]        cell_height_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [VALUE_BITS-1:0] value_ll_i,
  input  logic signed [VALUE_BITS-1:0] value_lr_i,
  input  logic signed [VALUE_BITS-1:0] value_ur_i,
  input  logic signed [VALUE_BITS-1:0] value_ul_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] interpolated_o
);

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned NW  = idw_pkg::mag_w(COORD_BITS, VALUE_BITS);
  localparam int unsigned DNW = idw_pkg::den_w(COORD_BITS);

  // Links between the front pipeline and the divider cells.
  logic           c_vld  [VB+1];
  logic           c_rdy  [VB+1];
  logic [NW-1:0]  rem_w  [VB+1];
  logic [DNW-1:0] den_w  [VB+1];
  logic [VB-1:0]  quo_w  [VB+1];
  logic           neg_w  [VB+1];
  logic           hit_w  [VB+1];
  logic [VB-1:0]  hres_w [VB+1];
  logic           front_rdy;

  idw_front #(.CB(COORD_BITS), .VB(VALUE_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (front_rdy),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .cell_width_i  (cell_width_i),
    .cell_height_i (cell_height_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .value_ll_i    (value_ll_i),
    .value_lr_i    (value_lr_i),
    .value_ur_i    (value_ur_i),
    .value_ul_i    (value_ul_i),
    .valid_o       (c_vld[0]),
    .ready_i       (c_rdy[0]),
    .mag_o         (rem_w[0]),
    .den_o         (den_w[0]),
    .neg_o         (neg_w[0]),
    .hit_o         (hit_w[0]),
    .hres_o        (hres_w[0])
  );

  assign in_stall_o = !front_rdy;
  assign quo_w[0]   = '0;

  // Divider row, one quotient bit per cell.
  for (genvar g = 0; g < VB; g++) begin : g_cell
    idw_cell #(.NW(NW), .DNW(DNW), .VB(VB), .SHIFT(VB - 1 - g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_vld[g]),
      .ready_o (c_rdy[g]),
      .rem_i   (rem_w[g]),
      .den_i   (den_w[g]),
      .quo_i   (quo_w[g]),
      .neg_i   (neg_w[g]),
      .hit_i   (hit_w[g]),
      .hres_i  (hres_w[g]),
      .valid_o (c_vld[g+1]),
      .ready_i (c_rdy[g+1]),
      .rem_o   (rem_w[g+1]),
      .den_o   (den_w[g+1]),
      .quo_o   (quo_w[g+1]),
      .neg_o   (neg_w[g+1]),
      .hit_o   (hit_w[g+1]),
      .hres_o  (hres_w[g+1])
    );
  end

  // Result: corner mean on an exact hit, else the signed quotient.
  assign c_rdy[VB]      = !out_stall_i;
  assign out_valid_o    = c_vld[VB];
  assign interpolated_o = hit_w[VB] ? hres_w[VB] : (neg_w[VB] ? -quo_w[VB] : quo_w[VB]);

`ifndef SYNTHESIS
  // With the output draining, every stage can move, so input is never held off.
  a_ready_when_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output drains");

  // The final remainder of a division stays below the divisor.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_w[VB]) |-> (rem_w[VB] < NW'(den_w[VB])))
    else $error("divider remainder not below divisor");

  // A weighted mean never exceeds the largest value magnitude, 1 << (VB - 1).
  a_quo_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_w[VB]) |-> (quo_w[VB] <= (VB'(1) << (VB - 1))))
    else $error("quotient out of value range");
`endif

endmodule
